/* src/hsa_pkg.sv */
`default_nettype none
package hsa_pkg;

    localparam int unsigned LEVEL_MAX  = 255;
    localparam int unsigned PCT_FULL   = 100;
    localparam int unsigned FRAC_BITS  = 16;
    // gain quotient width: 8 bit numerator above 16 fraction bits
    localparam int unsigned Q_W        = 24;
    localparam int unsigned DIV_STEPS  = 2;
    localparam int unsigned DIV_STAGES = Q_W / DIV_STEPS;
    localparam int unsigned PROD_W     = 36;
    localparam int unsigned BASE_W     = 26;
    localparam int unsigned NUM_W      = 37;

    typedef logic [2:0][7:0] t_chan;

    typedef struct packed {
        t_chan             ch;
        logic [7:0]        mx;
        logic [7:0]        mn;
        logic signed [7:0] pct;
    } t_s1;

    typedef struct packed {
        t_chan             ch;
        logic [8:0]        sum;
        logic [7:0]        delta;
        logic [7:0]        den;
        logic signed [7:0] pct;
    } t_s2;

    typedef struct packed {
        t_chan          ch;
        logic [8:0]     sum;
        logic           gray;
        logic           pos;
        logic [7:0]     dvs;
        logic [7:0]     rem;
        logic [Q_W-1:0] qn;
    } t_div;

    typedef struct packed {
        t_chan                              ch;
        logic                               gray;
        logic [2:0][PROD_W-1:0]             prod;
        logic [2:0][BASE_W-1:0]             base;
    } t_mul;

endpackage
`default_nettype wire

/* src/hsa_pix_if.sv */
`default_nettype none
interface hsa_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] blue_in;
    logic [7:0] green_in;
    logic [7:0] red_in;
    modport source (output valid, output blue_in, output green_in, output red_in, input ready);
    modport sink (input valid, input blue_in, input green_in, input red_in, output ready);
endinterface

interface hsa_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] blue_out;
    logic [7:0] green_out;
    logic [7:0] red_out;
    modport source (output valid, output blue_out, output green_out, output red_out,
                    input ready);
    modport sink (input valid, input blue_out, input green_out, input red_out,
                  output ready);
endinterface
`default_nettype wire

/* src/hsl_saturation_adjust.sv */
`default_nettype none
// hsl saturation adjust, one bgr pixel per beat
// throughput: one beat per cycle while the output is ready, set by the 17 stage pipeline with a
//   12 stage restoring divider (2 quotient bits per stage) for the gain
// reset: synchronous active low, clears all stage valids and sets the percent to 0
module hsl_saturation_adjust (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_we,
    input  wire  [7:0] i_cfg_data,
    hsa_in_if.sink     i_pix,
    hsa_out_if.source  o_pix
);

    localparam int unsigned NDIV = hsa_pkg::DIV_STAGES;
    // stage map: 0 minmax, 1 sum/den, 2 divider setup, 3..2+NDIV divider,
    // 3+NDIV multiply, 4+NDIV output register
    localparam int unsigned NS   = NDIV + 5;
    localparam int unsigned S_MUL = NDIV + 3;
    localparam int unsigned S_OUT = NDIV + 4;

    logic signed [7:0] r_pct;

    logic [NS-1:0] r_vld;
    logic [NS:0]   rdy;

    hsa_pkg::t_s1  r_s1, n_s1;
    hsa_pkg::t_s2  r_s2, n_s2;
    hsa_pkg::t_div r_dv [0:NDIV];
    hsa_pkg::t_div n_dv0;
    hsa_pkg::t_div n_dv [1:NDIV];
    hsa_pkg::t_mul r_mul, n_mul;
    hsa_pkg::t_chan r_out, n_out;

    // configuration register; the user must write it only while idle, the block does not enforce this
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pct <= '0;
        end else if (i_cfg_we) begin
            r_pct <= i_cfg_data;
        end
    end

    // per-stage ready: a stage loads when empty or when its beat moves on
    always_comb begin
        rdy[NS] = o_pix.ready;
        for (int k = NS - 1; k >= 0; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
    end

    assign i_pix.ready = rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (rdy[0]) begin
                r_vld[0] <= i_pix.valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // stage 0: min/max and percent clamp
    always_comb begin
        n_s1.ch = {i_pix.red_in, i_pix.green_in, i_pix.blue_in};
        n_s1.mx = i_pix.blue_in;
        n_s1.mn = i_pix.blue_in;
        for (int i = 1; i < 3; i++) begin
            if (n_s1.ch[i] > n_s1.mx) n_s1.mx = n_s1.ch[i];
            if (n_s1.ch[i] < n_s1.mn) n_s1.mn = n_s1.ch[i];
        end
        if (r_pct < -8'sd100) begin
            n_s1.pct = -8'sd100;
        end else if (r_pct > 8'sd100) begin
            n_s1.pct = 8'sd100;
        end else begin
            n_s1.pct = r_pct;
        end
    end

    // stage 1: sum, delta and saturation denominator
    always_comb begin
        logic [8:0] tmp;
        n_s2.ch    = r_s1.ch;
        n_s2.pct   = r_s1.pct;
        n_s2.sum   = {1'b0, r_s1.mx} + {1'b0, r_s1.mn};
        n_s2.delta = r_s1.mx - r_s1.mn;
        tmp        = 9'(2 * hsa_pkg::LEVEL_MAX) - n_s2.sum;
        n_s2.den   = (n_s2.sum < 9'(hsa_pkg::LEVEL_MAX)) ? n_s2.sum[7:0] : tmp[7:0];
    end

    // stage 2: pick gain numerator and divisor
    always_comb begin
        logic [6:0]  pmag;
        logic [16:0] lhs;
        logic [16:0] rhs;
        logic [7:0]  num;
        pmag = r_s2.pct[6:0];
        lhs  = 17'(pmag) * 17'(r_s2.den) + 17'(hsa_pkg::PCT_FULL) * 17'(r_s2.delta);
        rhs  = 17'(hsa_pkg::PCT_FULL) * 17'(r_s2.den);
        n_dv0.ch   = r_s2.ch;
        n_dv0.sum  = r_s2.sum;
        n_dv0.gray = (r_s2.delta == 8'd0);
        n_dv0.pos  = !r_s2.pct[7];
        n_dv0.rem  = '0;
        if (n_dv0.gray) begin
            num          = '0;
            n_dv0.dvs    = 8'd1;
        end else if (r_s2.pct[7]) begin
            num          = 8'(hsa_pkg::PCT_FULL) + 8'(r_s2.pct);
            n_dv0.dvs    = 8'(hsa_pkg::PCT_FULL);
        end else if (lhs >= rhs) begin
            num          = r_s2.den - r_s2.delta;
            n_dv0.dvs    = r_s2.delta;
        end else begin
            num          = {1'b0, pmag};
            n_dv0.dvs    = 8'(hsa_pkg::PCT_FULL) - {1'b0, pmag};
        end
        n_dv0.qn = {num, {hsa_pkg::FRAC_BITS{1'b0}}};
    end

    // divider stages: restoring steps, quotient shifts into qn
    always_comb begin
        for (int k = 1; k <= NDIV; k++) begin
            logic [8:0] rem9;
            n_dv[k] = r_dv[k-1];
            for (int j = 0; j < hsa_pkg::DIV_STEPS; j++) begin
                rem9 = {n_dv[k].rem, n_dv[k].qn[hsa_pkg::Q_W-1]};
                if (rem9 >= {1'b0, n_dv[k].dvs}) begin
                    rem9 = rem9 - {1'b0, n_dv[k].dvs};
                    n_dv[k].qn = {n_dv[k].qn[hsa_pkg::Q_W-2:0], 1'b1};
                end else begin
                    n_dv[k].qn = {n_dv[k].qn[hsa_pkg::Q_W-2:0], 1'b0};
                end
                n_dv[k].rem = rem9[7:0];
            end
        end
    end

    // multiply stage: (2c - sum) * gain and the base term
    always_comb begin
        logic signed [10:0]                 diff;
        logic [8:0]                         bsel;
        logic signed [hsa_pkg::PROD_W-1:0]  dwide;
        logic signed [hsa_pkg::PROD_W-1:0]  gwide;
        n_mul.ch   = r_dv[NDIV].ch;
        n_mul.gray = r_dv[NDIV].gray;
        gwide = $signed({{(hsa_pkg::PROD_W-hsa_pkg::Q_W){1'b0}}, r_dv[NDIV].qn});
        for (int i = 0; i < 3; i++) begin
            diff = $signed({2'b00, r_dv[NDIV].ch[i], 1'b0}) - $signed({2'b00, r_dv[NDIV].sum});
            // full product width so large gains do not wrap
            dwide = $signed({{(hsa_pkg::PROD_W-11){diff[10]}}, diff});
            n_mul.prod[i] = dwide * gwide;
            bsel = r_dv[NDIV].pos ? {r_dv[NDIV].ch[i], 1'b0} : r_dv[NDIV].sum;
            n_mul.base[i] = {1'b0, bsel, {hsa_pkg::FRAC_BITS{1'b0}}};
        end
    end

    // output stage: add, floor and clip to 0..255; gray pixels pass through unchanged
    always_comb begin
        logic signed [hsa_pkg::NUM_W-1:0] num;
        logic signed [hsa_pkg::NUM_W-1:0] v;
        for (int i = 0; i < 3; i++) begin
            num = $signed({{(hsa_pkg::NUM_W-hsa_pkg::PROD_W){r_mul.prod[i][hsa_pkg::PROD_W-1]}},
                           r_mul.prod[i]})
                + $signed({{(hsa_pkg::NUM_W-hsa_pkg::BASE_W){1'b0}}, r_mul.base[i]});
            v = num >>> (hsa_pkg::FRAC_BITS + 1);
            if (r_mul.gray) begin
                n_out[i] = r_mul.ch[i];
            end else if (num < 0) begin
                n_out[i] = 8'd0;
            end else if (v > hsa_pkg::NUM_W'(hsa_pkg::LEVEL_MAX)) begin
                n_out[i] = 8'(hsa_pkg::LEVEL_MAX);
            end else begin
                n_out[i] = v[7:0];
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (rdy[0])     r_s1  <= n_s1;
        if (rdy[1])     r_s2  <= n_s2;
        if (rdy[2])     r_dv[0] <= n_dv0;
        for (int k = 1; k <= NDIV; k++) begin
            if (rdy[k+2]) r_dv[k] <= n_dv[k];
        end
        if (rdy[S_MUL]) r_mul <= n_mul;
        if (rdy[S_OUT]) r_out <= n_out;
    end

    assign o_pix.valid     = r_vld[S_OUT];
    assign o_pix.blue_out  = r_out[0];
    assign o_pix.green_out = r_out[1];
    assign o_pix.red_out   = r_out[2];

    // divisor is never zero once the setup stage holds a beat
    a_dvs_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[2] |-> r_dv[0].dvs != 8'd0)
        else $error("divider setup with zero divisor");

    // remainder stays below divisor at the divider exit
    a_rem_lt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[S_MUL-1] |-> r_dv[NDIV].rem < r_dv[NDIV].dvs)
        else $error("divider remainder out of range");

    // input stalls only from output back pressure
    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_pix.ready |-> (o_pix.valid && !o_pix.ready))
        else $error("input stalled without output back pressure");

    // reset empties the pipeline
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_pix.valid)
        else $error("output valid right after reset");

endmodule
`default_nettype wire

/* test/hsa_checker.sv */
`timescale 1ns / 1ps
module hsa_checker (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_we,
    input  wire  [7:0] i_cfg_data,
    hsa_in_if.sink     i_pix,
    hsa_out_if.sink    o_pix,
    output int         o_errors,
    output int         o_pending,
    output int         o_beats
);
    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_pixel;

    logic signed [7:0] pct_q;
    t_pixel            expected_pixels[$];

    function automatic logic [7:0] clamp_level(longint num);
        longint v;
        if (num < 0) begin
            return 8'd0;
        end
        v = num >>> 17;
        if (v > 255) begin
            return 8'd255;
        end
        return v[7:0];
    endfunction

    function automatic t_pixel adjust_pixel(t_pixel px, logic signed [7:0] pct);
        longint c[3];
        longint mx, mn, sum, delta, den, gain, p;
        t_pixel r;
        c[0] = px.blue;
        c[1] = px.green;
        c[2] = px.red;
        mx = c[0];
        mn = c[0];
        for (int i = 1; i < 3; i++) begin
            if (c[i] > mx) mx = c[i];
            if (c[i] < mn) mn = c[i];
        end
        delta = mx - mn;
        if (delta == 0) begin
            return px;
        end
        p = pct;
        if (p < -100) p = -100;
        if (p > 100) p = 100;
        sum = mx + mn;
        den = (sum < 255) ? sum : (510 - sum);
        if (p >= 0) begin
            if (p * den + 100 * delta >= 100 * den) begin
                gain = ((den - delta) * 65536) / delta;
            end else begin
                gain = (p * 65536) / (100 - p);
            end
            for (int i = 0; i < 3; i++) begin
                c[i] = 2 * c[i] * 65536 + (2 * c[i] - sum) * gain;
            end
        end else begin
            gain = ((100 + p) * 65536) / 100;
            for (int i = 0; i < 3; i++) begin
                c[i] = sum * 65536 + (2 * c[i] - sum) * gain;
            end
        end
        r.blue  = clamp_level(c[0]);
        r.green = clamp_level(c[1]);
        r.red   = clamp_level(c[2]);
        return r;
    endfunction

    assign o_pending = expected_pixels.size();

    always @(posedge i_clk) begin
        t_pixel want;
        if (!i_rst_n) begin
            pct_q <= '0;
            o_errors <= 0;
            o_beats <= 0;
            expected_pixels.delete();
        end else begin
            if (i_cfg_we) pct_q <= i_cfg_data;
            if (i_pix.valid && i_pix.ready) begin
                expected_pixels.push_back(adjust_pixel(
                    '{blue: i_pix.blue_in, green: i_pix.green_in, red: i_pix.red_in}, pct_q));
            end
            if (o_pix.valid && o_pix.ready) begin
                o_beats <= o_beats + 1;
                if (expected_pixels.size() == 0) begin
                    $error("unexpected output beat");
                    o_errors <= o_errors + 1;
                end else begin
                    want = expected_pixels.pop_front();
                    if (o_pix.blue_out !== want.blue || o_pix.green_out !== want.green ||
                        o_pix.red_out !== want.red) begin
                        o_errors <= o_errors + 1;
                        if (o_pix.blue_out !== want.blue)
                            $error("blue_out expected %0d got %0d", want.blue, o_pix.blue_out);
                        if (o_pix.green_out !== want.green)
                            $error("green_out expected %0d got %0d", want.green,
                                   o_pix.green_out);
                        if (o_pix.red_out !== want.red)
                            $error("red_out expected %0d got %0d", want.red, o_pix.red_out);
                    end
                end
            end
        end
    end
endmodule

/* test/tb_hsl_saturation_adjust.sv */
`timescale 1ns / 1ps
module tb_hsl_saturation_adjust;
    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic [7:0] i_cfg_data = '0;
    int         errors, pending, beats;
    int         pixels_sent = 0;
    bit         steady = 0;     // no idling in the closing stretch

    hsa_in_if  pix_in ();
    hsa_out_if pix_out ();

    hsl_saturation_adjust DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_pix      (pix_in.sink),
        .o_pix      (pix_out.source)
    );

    hsa_checker checker_inst (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_pix      (pix_in.sink),
        .o_pix      (pix_out.sink),
        .o_errors   (errors),
        .o_pending  (pending),
        .o_beats    (beats)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // sink side: ready drops for bursts of random length
    initial begin
        pix_out.ready = 1'b0;
        @(negedge i_clk);
        forever begin
            if (!steady && $urandom_range(0, 5) == 0) begin
                pix_out.ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(negedge i_clk);
            end else begin
                pix_out.ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(negedge i_clk);
            end
        end
    end

    // one beat; valid stays up while beats follow back to back
    task automatic send_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r);
        if (!steady && $urandom_range(0, 4) == 0) begin
            pix_in.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        pix_in.valid    <= 1'b1;
        pix_in.blue_in  <= b;
        pix_in.green_in <= g;
        pix_in.red_in   <= r;
        @(posedge i_clk);
        while (!pix_in.ready) @(posedge i_clk);
        @(negedge i_clk);
        pixels_sent++;
    endtask

    // drain and let the pipeline settle before touching the register
    task automatic set_percent(int pct);
        pix_in.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= pct[7:0];
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic random_pixels(int n);
        logic [7:0] b, g, r;
        for (int k = 0; k < n; k++) begin
            b = 8'($urandom);
            g = 8'($urandom);
            r = 8'($urandom);
            case ($urandom_range(0, 7))
                0: begin g = b; r = b; end                     // gray
                1: begin g = b; end
                2: begin
                    b = 8'($urandom_range(0, 8));
                    r = 8'($urandom_range(247, 255));
                end
                default: ;
            endcase
            send_pixel(b, g, r);
        end
    endtask

    initial begin
        int pcts[] = '{0, 100, -100, 50, -50, 127, -128, 1, -1, 99, -99, 75, -20};
        pix_in.valid    = 1'b0;
        pix_in.blue_in  = '0;
        pix_in.green_in = '0;
        pix_in.red_in   = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: reset percent, extremes, gray, dark and bright sums
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd0, 8'd255, 8'd128);
        set_percent(100);
        send_pixel(8'd0, 8'd255, 8'd128);
        send_pixel(8'd10, 8'd20, 8'd30);
        send_pixel(8'd200, 8'd250, 8'd230);
        send_pixel(8'd127, 8'd128, 8'd127);
        send_pixel(8'd90, 8'd90, 8'd90);
        set_percent(-100);
        send_pixel(8'd0, 8'd255, 8'd1);
        send_pixel(8'd10, 8'd20, 8'd31);
        set_percent(127);
        send_pixel(8'd40, 8'd80, 8'd60);
        set_percent(-128);
        send_pixel(8'd40, 8'd80, 8'd60);
        set_percent(30);
        send_pixel(8'd100, 8'd110, 8'd120);
        send_pixel(8'd1, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd254, 8'd255);

        // random phases across settings
        foreach (pcts[i]) begin
            set_percent(pcts[i]);
            random_pixels(110);
        end
        for (int i = 0; i < 4; i++) begin
            set_percent(int'($urandom_range(0, 255)));
            random_pixels(110);
        end
        steady = 1;
        random_pixels(80);
        pix_in.valid <= 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (30) @(negedge i_clk);
        $display("%0d pixels sent and %0d checked over %0d percent settings", pixels_sent,
                 beats, pcts.size() + 10);
        if (errors == 0) begin
            $display("tb_hsl_saturation_adjust passed");
        end else begin
            $display("tb_hsl_saturation_adjust failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("tb_hsl_saturation_adjust failed");
        $finish;
    end
endmodule
